### src/gdr_pkg.sv
package gdr_pkg;

	// Node space and storage geometry
	localparam int MAX_NODES = 64;
	localparam int NODE_BITS = $clog2(MAX_NODES);
	localparam int CNT_BITS = NODE_BITS + 1;
	localparam int ADDR_BITS = 2 * NODE_BITS;
	localparam int DEPTH = 1 << ADDR_BITS;
	localparam int WEIGHT_BITS = 16;
	// A shortest path has at most MAX_NODES - 1 hops
	localparam int DIST_BITS = WEIGHT_BITS + NODE_BITS;

	// Port field widths
	localparam int CFG_W = 7;
	localparam int CMD_W = 1;
	localparam int IN_NODE_W = 6;
	localparam int IN_WEIGHT_W = 16;
	localparam int OUT_DIST_W = 22;

	localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_FETCH,
		ST_RELAX,
		ST_REDUCE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                   present;
		logic [WEIGHT_BITS-1:0] weight;
	} edge_ent_t;

	typedef struct packed {
		logic                 reached;
		logic [DIST_BITS-1:0] value;
	} dist_ent_t;

	typedef struct packed {
		logic                   valid;
		logic [ADDR_BITS-1:0]   addr;
		logic [WEIGHT_BITS-1:0] weight;
	} edge_add_t;

	typedef struct packed {
		logic                 en;
		logic [ADDR_BITS-1:0] addr;
	} sweep_t;

	typedef struct packed {
		logic                 en;
		logic [ADDR_BITS-1:0] addr;
		dist_ent_t            data;
	} dist_wr_t;

	typedef struct packed {
		logic                 upd;
		logic [DIST_BITS-1:0] value;
	} relax_res_t;

	function automatic logic [WEIGHT_BITS-1:0] fit_weight(input logic [IN_WEIGHT_W-1:0] w);
		logic [IN_WEIGHT_W+WEIGHT_BITS-1:0] wide;
		wide = {{WEIGHT_BITS{1'b0}}, w};
		return wide[WEIGHT_BITS-1:0];
	endfunction

	function automatic logic [NODE_BITS-1:0] node_in(input logic [IN_NODE_W-1:0] v);
		logic [IN_NODE_W+NODE_BITS-1:0] wide;
		wide = {{NODE_BITS{1'b0}}, v};
		return wide[NODE_BITS-1:0];
	endfunction

	function automatic logic [IN_NODE_W-1:0] node_out(input logic [NODE_BITS-1:0] v);
		logic [IN_NODE_W+NODE_BITS-1:0] wide;
		wide = {{IN_NODE_W{1'b0}}, v};
		return wide[IN_NODE_W-1:0];
	endfunction

	function automatic logic [OUT_DIST_W-1:0] sat_out(input logic [DIST_BITS-1:0] v);
		logic [DIST_BITS+OUT_DIST_W-1:0] wide;
		logic [DIST_BITS+OUT_DIST_W-1:0] lim;
		wide = {{OUT_DIST_W{1'b0}}, v};
		lim = {{DIST_BITS{1'b0}}, {OUT_DIST_W{1'b1}}};
		if (wide > lim) begin
			return {OUT_DIST_W{1'b1}};
		end
		return wide[OUT_DIST_W-1:0];
	endfunction

endpackage

### src/graph_diameter_radius_unit.sv
// All-pairs shortest path engine that reports graph diameter and radius. An add-edge request
// (command 0) stores a directed weighted edge between nodes below node_count, keeping the
// lighter weight when a pair repeats; edge requests are taken one per cycle while the block
// is idle and give no response. A compute request (command 1) sweeps the 4096-entry edge
// store once, seeding the distance store and clearing the edges, then runs the relaxation
// sweep with one shared add-and-compare unit: per intermediate node k and source i, a fetch
// step reads the i-to-k distance and one relax step per target relaxes row i, the pace
// bounded by the single write port of the distance store. A final scan over all n*n pairs
// finds the diameter, its first source/target pair and the radius, and one response is
// posted. Here n = min(node_count, 64); the block returns to idle as the response is posted,
// ready for the next request; with one node or none the relaxation and the scan are skipped.
// A stalled response holds the block in its final step. After reset the edge store is
// cleared by one full sweep; requests stall meanwhile, configuration writes are taken.
module graph_diameter_radius_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gdr_pkg::CFG_W-1:0]         cfg_wr_data,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [gdr_pkg::CMD_W-1:0]         command,
	input  logic [gdr_pkg::IN_NODE_W-1:0]     from_node,
	input  logic [gdr_pkg::IN_NODE_W-1:0]     to_node,
	input  logic [gdr_pkg::IN_WEIGHT_W-1:0]   weight,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              graph_valid,
	output logic                              pair_found,
	output logic [gdr_pkg::OUT_DIST_W-1:0]    diameter,
	output logic [gdr_pkg::IN_NODE_W-1:0]     source_node,
	output logic [gdr_pkg::IN_NODE_W-1:0]     target_node,
	output logic [gdr_pkg::OUT_DIST_W-1:0]    radius
);

	localparam int CW = gdr_pkg::CFG_W + gdr_pkg::CNT_BITS;
	localparam int FW = gdr_pkg::IN_NODE_W + gdr_pkg::CNT_BITS;

	gdr_pkg::state_t state_q;
	gdr_pkg::state_t state_d;

	// configuration and node count
	logic [gdr_pkg::CFG_W-1:0]     node_count_q;
	logic [CW-1:0]                 count_wide;
	logic [gdr_pkg::CNT_BITS-1:0]  n_use;
	logic [gdr_pkg::CNT_BITS-1:0]  n_m1_wide;
	logic [gdr_pkg::NODE_BITS-1:0] n_m1;
	logic                          n_multi;
	logic                          n_single;

	// sequencer counters and flags
	logic                          req_acc;
	logic                          start;
	logic [gdr_pkg::ADDR_BITS-1:0] sweep_q;
	logic                          sweep_last;
	logic [gdr_pkg::NODE_BITS-1:0] k_q;
	logic [gdr_pkg::NODE_BITS-1:0] i_q;
	logic [gdr_pkg::NODE_BITS-1:0] j_q;
	logic                          k_last;
	logic                          i_last;
	logic                          j_last;
	logic                          fin_load;

	// edge request path
	logic                          from_ok;
	logic                          to_ok;
	gdr_pkg::edge_add_t            add;
	gdr_pkg::sweep_t               sweep;
	gdr_pkg::edge_ent_t            sweep_data;

	// pipeline stage one
	logic                          init_s1;
	logic [gdr_pkg::ADDR_BITS-1:0] init_addr_s1;
	logic                          fetch_s1;
	logic                          relax_s1;
	logic                          red_s1;
	logic                          red_last_s1;
	logic [gdr_pkg::NODE_BITS-1:0] i_s1;
	logic [gdr_pkg::NODE_BITS-1:0] j_s1;

	// distance path
	logic [gdr_pkg::NODE_BITS-1:0] init_i;
	logic [gdr_pkg::NODE_BITS-1:0] init_j;
	logic                          init_in;
	gdr_pkg::dist_ent_t            init_ent;
	logic [gdr_pkg::ADDR_BITS-1:0] rd_a_addr;
	logic [gdr_pkg::ADDR_BITS-1:0] rd_b_addr;
	gdr_pkg::dist_ent_t            rd_a_data;
	gdr_pkg::dist_ent_t            rd_b_data;
	gdr_pkg::dist_ent_t            dik_q;
	gdr_pkg::relax_res_t           relax_res;
	gdr_pkg::dist_wr_t             dwr;

	// reduction
	logic [gdr_pkg::DIST_BITS-1:0] diam_q;
	logic [gdr_pkg::DIST_BITS-1:0] ecc_q;
	logic [gdr_pkg::DIST_BITS-1:0] rad_q;
	logic [gdr_pkg::DIST_BITS-1:0] ecc_new;
	logic [gdr_pkg::NODE_BITS-1:0] src_q;
	logic [gdr_pkg::NODE_BITS-1:0] dst_q;
	logic                          found_q;
	logic                          red_hit;

	// response register
	logic                              rsp_valid_q;
	logic                              graph_valid_q;
	logic                              pair_found_q;
	logic [gdr_pkg::OUT_DIST_W-1:0]    diameter_q;
	logic [gdr_pkg::IN_NODE_W-1:0]     source_node_q;
	logic [gdr_pkg::IN_NODE_W-1:0]     target_node_q;
	logic [gdr_pkg::OUT_DIST_W-1:0]    radius_q;

	// Clamp node_count to the node space and derive the loop bound.
	always_comb begin
		count_wide = {{gdr_pkg::CNT_BITS{1'b0}}, node_count_q};
		if (count_wide > CW'(gdr_pkg::MAX_NODES)) begin
			n_use = gdr_pkg::CNT_BITS'(gdr_pkg::MAX_NODES);
		end else begin
			n_use = count_wide[gdr_pkg::CNT_BITS-1:0];
		end
		n_m1_wide = n_use - gdr_pkg::CNT_BITS'(1);
		n_m1 = n_m1_wide[gdr_pkg::NODE_BITS-1:0];
		n_multi = n_use > gdr_pkg::CNT_BITS'(1);
		n_single = n_use == gdr_pkg::CNT_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	assign req_acc = req_valid && !req_stall;
	assign start = req_acc && (command == gdr_pkg::CMD_COMPUTE);
	assign sweep_last = sweep_q == {gdr_pkg::ADDR_BITS{1'b1}};
	assign k_last = k_q == n_m1;
	assign i_last = i_q == n_m1;
	assign j_last = j_q == n_m1;
	// hold the result until the last scan step has landed and the response slot is free
	assign fin_load = !red_s1 && !init_s1 && (!rsp_valid_q || !rsp_stall);

	// Edge request: drop edges whose endpoints are not below the node count.
	always_comb begin
		from_ok = {{gdr_pkg::CNT_BITS{1'b0}}, from_node} < {{gdr_pkg::IN_NODE_W{1'b0}}, n_use};
		to_ok = {{gdr_pkg::CNT_BITS{1'b0}}, to_node} < {{gdr_pkg::IN_NODE_W{1'b0}}, n_use};
		add.valid = req_acc && (command == gdr_pkg::CMD_ADD_EDGE) && from_ok && to_ok;
		add.addr = {gdr_pkg::node_in(from_node), gdr_pkg::node_in(to_node)};
		add.weight = gdr_pkg::fit_weight(weight);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gdr_pkg::ST_CLEAR: begin
				if (sweep_last) state_d = gdr_pkg::ST_IDLE;
			end
			gdr_pkg::ST_IDLE: begin
				if (start) state_d = gdr_pkg::ST_INIT;
			end
			gdr_pkg::ST_INIT: begin
				if (sweep_last) state_d = n_multi ? gdr_pkg::ST_FETCH : gdr_pkg::ST_FINISH;
			end
			gdr_pkg::ST_FETCH: begin
				state_d = gdr_pkg::ST_RELAX;
			end
			gdr_pkg::ST_RELAX: begin
				if (j_last) begin
					state_d = (i_last && k_last) ? gdr_pkg::ST_REDUCE : gdr_pkg::ST_FETCH;
				end
			end
			gdr_pkg::ST_REDUCE: begin
				if (j_last && i_last) state_d = gdr_pkg::ST_FINISH;
			end
			gdr_pkg::ST_FINISH: begin
				if (fin_load) state_d = gdr_pkg::ST_IDLE;
			end
			default: begin
				state_d = gdr_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: stall, sweep and distance read addresses.
	always_comb begin
		req_stall = 1'b1;
		sweep.en = 1'b0;
		sweep.addr = sweep_q;
		rd_a_addr = {k_q, j_q};
		rd_b_addr = {i_q, j_q};
		unique case (state_q)
			gdr_pkg::ST_CLEAR, gdr_pkg::ST_INIT: begin
				sweep.en = 1'b1;
			end
			gdr_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			gdr_pkg::ST_FETCH: begin
				rd_a_addr = {i_q, k_q};
			end
			gdr_pkg::ST_RELAX, gdr_pkg::ST_REDUCE, gdr_pkg::ST_FINISH: begin
				req_stall = 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdr_pkg::ST_CLEAR;
			sweep_q <= '0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				gdr_pkg::ST_CLEAR, gdr_pkg::ST_INIT: begin
					// wraps back to zero at the end of the sweep
					sweep_q <= sweep_q + 1'b1;
					k_q <= '0;
					i_q <= '0;
					j_q <= '0;
				end
				gdr_pkg::ST_FETCH: begin
					j_q <= '0;
				end
				gdr_pkg::ST_RELAX: begin
					if (j_last) begin
						j_q <= '0;
						if (i_last) begin
							i_q <= '0;
							k_q <= k_q + 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				gdr_pkg::ST_REDUCE: begin
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				gdr_pkg::ST_IDLE, gdr_pkg::ST_FINISH: begin
					k_q <= '0;
					i_q <= '0;
					j_q <= '0;
				end
				default: begin
					sweep_q <= '0;
				end
			endcase
		end
	end

	// Stage one flags; payload stages follow the counters every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_s1 <= 1'b0;
			fetch_s1 <= 1'b0;
			relax_s1 <= 1'b0;
			red_s1 <= 1'b0;
		end else begin
			init_s1 <= state_q == gdr_pkg::ST_INIT;
			fetch_s1 <= state_q == gdr_pkg::ST_FETCH;
			relax_s1 <= state_q == gdr_pkg::ST_RELAX;
			red_s1 <= state_q == gdr_pkg::ST_REDUCE;
		end
	end

	always_ff @(posedge clk) begin
		init_addr_s1 <= sweep_q;
		i_s1 <= i_q;
		j_s1 <= j_q;
		red_last_s1 <= j_last;
		// latch the source-to-intermediate distance for the whole row
		if (fetch_s1) begin
			dik_q <= rd_a_data;
		end
	end

	gdr_edge_store u_edge_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.add        (add),
		.sweep      (sweep),
		.sweep_data (sweep_data)
	);

	// Seed distances from the edge just read: zero on the diagonal, the edge weight
	// where an edge is present, unreached otherwise. Entries beyond n are left alone.
	always_comb begin
		init_i = init_addr_s1[gdr_pkg::ADDR_BITS-1:gdr_pkg::NODE_BITS];
		init_j = init_addr_s1[gdr_pkg::NODE_BITS-1:0];
		init_in = ({1'b0, init_i} < n_use) && ({1'b0, init_j} < n_use);
		if (init_i == init_j) begin
			init_ent.reached = 1'b1;
			init_ent.value = '0;
		end else begin
			init_ent.reached = sweep_data.present;
			if (sweep_data.present) begin
				init_ent.value = {{gdr_pkg::NODE_BITS{1'b0}}, sweep_data.weight};
			end else begin
				init_ent.value = '0;
			end
		end
		if (init_s1) begin
			dwr.en = init_in;
			dwr.addr = init_addr_s1;
			dwr.data = init_ent;
		end else begin
			dwr.en = relax_s1 && relax_res.upd;
			dwr.addr = {i_s1, j_s1};
			dwr.data.reached = 1'b1;
			dwr.data.value = relax_res.value;
		end
	end

	gdr_dist_store u_dist_store (
		.clk       (clk),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.wr        (dwr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	gdr_relax_unit u_relax_unit (
		.d_ik (dik_q),
		.d_kj (rd_a_data),
		.d_ij (rd_b_data),
		.res  (relax_res)
	);

	// Scan: a strictly larger distance moves the diameter, so the first pair in
	// source-then-target order wins; the row maximum folds into the radius at row end.
	always_comb begin
		red_hit = rd_b_data.reached && (rd_b_data.value > diam_q);
		if (rd_b_data.reached && (rd_b_data.value > ecc_q)) begin
			ecc_new = rd_b_data.value;
		end else begin
			ecc_new = ecc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			found_q <= 1'b0;
			ecc_q <= '0;
			rad_q <= '1;
		end else if (start) begin
			diam_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			found_q <= 1'b0;
			ecc_q <= '0;
			rad_q <= '1;
		end else if (red_s1) begin
			if (red_hit) begin
				diam_q <= rd_b_data.value;
				src_q <= i_s1;
				dst_q <= j_s1;
				found_q <= 1'b1;
			end
			if (red_last_s1) begin
				ecc_q <= '0;
				if (ecc_new < rad_q) begin
					rad_q <= ecc_new;
				end
			end else begin
				ecc_q <= ecc_new;
			end
		end
	end

	// Response register: an empty graph reports zeros, a single node reports a
	// found pair at node zero with zero distances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == gdr_pkg::ST_FINISH) && fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == gdr_pkg::ST_FINISH) && fin_load) begin
			graph_valid_q <= n_use != '0;
			pair_found_q <= n_single || (n_multi && found_q);
			if (n_multi) begin
				diameter_q <= gdr_pkg::sat_out(diam_q);
				source_node_q <= gdr_pkg::node_out(src_q);
				target_node_q <= gdr_pkg::node_out(dst_q);
				radius_q <= gdr_pkg::sat_out(rad_q);
			end else begin
				diameter_q <= '0;
				source_node_q <= '0;
				target_node_q <= '0;
				radius_q <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign graph_valid = graph_valid_q;
	assign pair_found = pair_found_q;
	assign diameter = diameter_q;
	assign source_node = source_node_q;
	assign target_node = target_node_q;
	assign radius = radius_q;

endmodule

### src/gdr_edge_store.sv
module gdr_edge_store (
	input  logic                clk,
	input  logic                arst_n,
	input  gdr_pkg::edge_add_t  add,
	input  gdr_pkg::sweep_t     sweep,
	output gdr_pkg::edge_ent_t  sweep_data
);

	gdr_pkg::edge_ent_t mem_q [gdr_pkg::DEPTH];
	gdr_pkg::edge_ent_t rd_q;
	gdr_pkg::edge_ent_t cur;
	gdr_pkg::edge_ent_t wr_data;
	gdr_pkg::edge_ent_t fwd_data_q;

	logic                            add_valid_s1;
	logic [gdr_pkg::ADDR_BITS-1:0]   add_addr_s1;
	logic [gdr_pkg::WEIGHT_BITS-1:0] add_weight_s1;
	logic                            fwd_valid_q;
	logic [gdr_pkg::ADDR_BITS-1:0]   fwd_addr_q;
	logic                            add_we;
	logic                            wr_en;
	logic [gdr_pkg::ADDR_BITS-1:0]   wr_addr;
	logic [gdr_pkg::ADDR_BITS-1:0]   rd_addr;

	always_comb begin
		// take the entry just written when back-to-back requests hit the same pair
		if (fwd_valid_q && (fwd_addr_q == add_addr_s1)) begin
			cur = fwd_data_q;
		end else begin
			cur = rd_q;
		end
		add_we = add_valid_s1 && (!cur.present || (add_weight_s1 < cur.weight));
		wr_en = sweep.en || add_we;
		rd_addr = sweep.en ? sweep.addr : add.addr;
		if (sweep.en) begin
			wr_addr = sweep.addr;
			wr_data = '0;
		end else begin
			wr_addr = add_addr_s1;
			wr_data.present = 1'b1;
			wr_data.weight = add_weight_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
		add_addr_s1 <= add.addr;
		add_weight_s1 <= add.weight;
		fwd_addr_q <= add_addr_s1;
		fwd_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			add_valid_s1 <= add.valid;
			fwd_valid_q <= add_we && !sweep.en;
		end
	end

	assign sweep_data = rd_q;

endmodule

### src/gdr_dist_store.sv
module gdr_dist_store (
	input  logic                           clk,
	input  logic [gdr_pkg::ADDR_BITS-1:0]  rd_a_addr,
	input  logic [gdr_pkg::ADDR_BITS-1:0]  rd_b_addr,
	input  gdr_pkg::dist_wr_t              wr,
	output gdr_pkg::dist_ent_t             rd_a_data,
	output gdr_pkg::dist_ent_t             rd_b_data
);

	gdr_pkg::dist_ent_t mem_q [gdr_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_a_data <= mem_q[rd_a_addr];
		rd_b_data <= mem_q[rd_b_addr];
	end

endmodule

### src/gdr_relax_unit.sv
module gdr_relax_unit (
	input  gdr_pkg::dist_ent_t   d_ik,
	input  gdr_pkg::dist_ent_t   d_kj,
	input  gdr_pkg::dist_ent_t   d_ij,
	output gdr_pkg::relax_res_t  res
);

	logic [gdr_pkg::DIST_BITS:0] sum;

	always_comb begin
		sum = {1'b0, d_ik.value} + {1'b0, d_kj.value};
		res.upd = d_ik.reached && d_kj.reached &&
			(!d_ij.reached || (sum < {1'b0, d_ij.value}));
		// a shorter path always fits the distance width
		res.value = sum[gdr_pkg::DIST_BITS-1:0];
	end

endmodule

### bench/gdr_checker.sv
module gdr_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic [gdr_pkg::CFG_W-1:0]                cfg_wr_data,
	input  logic                                     req_valid,
	input  logic                                     req_stall,
	input  logic [gdr_pkg::CMD_W-1:0]                command,
	input  logic [gdr_pkg::IN_NODE_W-1:0]            from_node,
	input  logic [gdr_pkg::IN_NODE_W-1:0]            to_node,
	input  logic [gdr_pkg::IN_WEIGHT_W-1:0]          weight,
	input  logic                                     rsp_valid,
	input  logic                                     rsp_stall,
	input  logic                                     graph_valid,
	input  logic                                     pair_found,
	input  logic [gdr_pkg::OUT_DIST_W-1:0]           diameter,
	input  logic [gdr_pkg::IN_NODE_W-1:0]            source_node,
	input  logic [gdr_pkg::IN_NODE_W-1:0]            target_node,
	input  logic [gdr_pkg::OUT_DIST_W-1:0]           radius,
	output int                                       fail_count,
	output int                                       pending
);

	localparam bit [31:0] DIST_CAP = (32'd1 << gdr_pkg::OUT_DIST_W) - 32'd1;

	typedef struct packed {
		logic                           valid;
		logic                           found;
		logic [gdr_pkg::OUT_DIST_W-1:0] diam;
		logic [gdr_pkg::IN_NODE_W-1:0]  src;
		logic [gdr_pkg::IN_NODE_W-1:0]  dst;
		logic [gdr_pkg::OUT_DIST_W-1:0] rad;
	} summary_t;

	summary_t                      summary_q[$];
	bit                            edge_set[gdr_pkg::DEPTH];
	bit [gdr_pkg::WEIGHT_BITS-1:0] edge_len[gdr_pkg::DEPTH];
	bit                            reach[gdr_pkg::DEPTH];
	bit [31:0]                     span[gdr_pkg::DEPTH];
	bit [gdr_pkg::CFG_W-1:0]       node_total;
	int                            errors;

	task automatic clear_edge_store();
		for (int a = 0; a < gdr_pkg::DEPTH; a++) begin
			edge_set[a] = 1'b0;
			edge_len[a] = '0;
		end
	endtask

	function automatic int nodes_in_use();
		return (node_total > gdr_pkg::MAX_NODES) ? gdr_pkg::MAX_NODES : int'(node_total);
	endfunction

	// Floyd-Warshall over the nodes in use, then diameter, first pair and radius
	function automatic summary_t solve_graph(int n);
		summary_t  r;
		int        ik;
		int        kj;
		int        ij;
		bit [31:0] s;
		bit [31:0] ecc;
		bit [31:0] best;
		bit [31:0] least;
		r = '0;
		if (n == 1) begin
			r.valid = 1'b1;
			r.found = 1'b1;
		end else if (n > 1) begin
			r.valid = 1'b1;
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					ij = i * gdr_pkg::MAX_NODES + j;
					reach[ij] = (i == j) ? 1'b1 : edge_set[ij];
					span[ij] = (i != j && edge_set[ij]) ? 32'(edge_len[ij]) : 32'd0;
				end
			end
			for (int k = 0; k < n; k++) begin
				for (int i = 0; i < n; i++) begin
					ik = i * gdr_pkg::MAX_NODES + k;
					if (reach[ik]) begin
						for (int j = 0; j < n; j++) begin
							kj = k * gdr_pkg::MAX_NODES + j;
							ij = i * gdr_pkg::MAX_NODES + j;
							if (reach[kj]) begin
								s = span[ik] + span[kj];
								if (!reach[ij] || s < span[ij]) begin
									reach[ij] = 1'b1;
									span[ij] = s;
								end
							end
						end
					end
				end
			end
			best = '0;
			least = '1;
			for (int i = 0; i < n; i++) begin
				ecc = '0;
				for (int j = 0; j < n; j++) begin
					ij = i * gdr_pkg::MAX_NODES + j;
					if (reach[ij]) begin
						if (span[ij] > best) begin
							best = span[ij];
							r.src = gdr_pkg::IN_NODE_W'(i);
							r.dst = gdr_pkg::IN_NODE_W'(j);
							r.found = 1'b1;
						end
						if (span[ij] > ecc)
							ecc = span[ij];
					end
				end
				if (ecc < least)
					least = ecc;
			end
			r.diam = (best > DIST_CAP) ? DIST_CAP[gdr_pkg::OUT_DIST_W-1:0] :
				best[gdr_pkg::OUT_DIST_W-1:0];
			r.rad = (least > DIST_CAP) ? DIST_CAP[gdr_pkg::OUT_DIST_W-1:0] :
				least[gdr_pkg::OUT_DIST_W-1:0];
		end
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		summary_t want;
		int       n;
		int       e;
		if (!arst_n) begin
			clear_edge_store();
			node_total = '0;
			summary_q.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// a request at this edge still sees the node count from before it
			n = nodes_in_use();
			if (req_valid && !req_stall) begin
				if (command == gdr_pkg::CMD_COMPUTE) begin
					summary_q.insert(summary_q.size(), solve_graph(n));
					clear_edge_store();
				end else if (int'(from_node) < n && int'(to_node) < n) begin
					// keep the lighter weight on a repeated pair
					e = int'(from_node) * gdr_pkg::MAX_NODES + int'(to_node);
					if (!edge_set[e] || weight[gdr_pkg::WEIGHT_BITS-1:0] < edge_len[e]) begin
						edge_set[e] = 1'b1;
						edge_len[e] = weight[gdr_pkg::WEIGHT_BITS-1:0];
					end
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (summary_q.size() == 0) begin
					$error("result with no compute request outstanding");
					errors++;
				end else begin
					want = summary_q.pop_front();
					check_field("graph_valid", want.valid, graph_valid);
					check_field("pair_found", want.found, pair_found);
					check_field("diameter", want.diam, diameter);
					check_field("source_node", want.src, source_node);
					check_field("target_node", want.dst, target_node);
					check_field("radius", want.rad, radius);
				end
			end
			if (cfg_wr_en)
				node_total = cfg_wr_data;
			fail_count <= errors;
			pending <= summary_q.size();
		end
	end

endmodule

### bench/tb.sv
module tb;

	localparam int NODE_W = gdr_pkg::IN_NODE_W;
	localparam int WEIGHT_W = gdr_pkg::IN_WEIGHT_W;
	localparam int COUNT_W = gdr_pkg::CFG_W;
	// Request count that ends the random part (the closing chain included)
	localparam int ITEM_GOAL = 1600;
	// Full-size chain sent last, one edge per node pair along the line
	localparam int CHAIN_ITEMS = gdr_pkg::MAX_NODES;
	// Edge requests give no result: let the pipe empty before a register write
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES = 64;
	// A 64-node compute moves neither channel for a long stretch; allow a wide margin
	localparam int QUIET_LIMIT = 1000000;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [gdr_pkg::CFG_W-1:0]           cfg_wr_data;
	logic                                req_valid;
	logic                                req_stall;
	logic [gdr_pkg::CMD_W-1:0]           command;
	logic [gdr_pkg::IN_NODE_W-1:0]       from_node;
	logic [gdr_pkg::IN_NODE_W-1:0]       to_node;
	logic [gdr_pkg::IN_WEIGHT_W-1:0]     weight;
	logic                                rsp_valid;
	logic                                rsp_stall;
	logic                                graph_valid;
	logic                                pair_found;
	logic [gdr_pkg::OUT_DIST_W-1:0]      diameter;
	logic [gdr_pkg::IN_NODE_W-1:0]       source_node;
	logic [gdr_pkg::IN_NODE_W-1:0]       target_node;
	logic [gdr_pkg::OUT_DIST_W-1:0]      radius;

	int fail_count;
	int pending;
	int sent;
	int quiet_cycles;
	bit calm_tx;
	bit calm_rx;

	graph_diameter_radius_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.command     (command),
		.from_node   (from_node),
		.to_node     (to_node),
		.weight      (weight),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.graph_valid (graph_valid),
		.pair_found  (pair_found),
		.diameter    (diameter),
		.source_node (source_node),
		.target_node (target_node),
		.radius      (radius)
	);

	gdr_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.command     (command),
		.from_node   (from_node),
		.to_node     (to_node),
		.weight      (weight),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.graph_valid (graph_valid),
		.pair_found  (pair_found),
		.diameter    (diameter),
		.source_node (source_node),
		.target_node (target_node),
		.radius      (radius),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Drive one request: idle for a drawn gap, then hold it until the block takes it.
	// Returns just after the accepting rising edge, so the next call moves at the
	// following falling edge and valid is never dropped and raised in one step.
	task automatic push(logic [gdr_pkg::CMD_W-1:0] op, logic [NODE_W-1:0] f,
			logic [NODE_W-1:0] t, logic [WEIGHT_W-1:0] w);
		int gap;
		gap = calm_tx ? 0 : int'($urandom_range(0, 15));
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		command <= op;
		from_node <= f;
		to_node <= t;
		weight <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	// Drop valid and hold off until every compute result is back and the edge pipe
	// has drained; only then may node_count change.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_node_count(logic [COUNT_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One load/compute round with random content over the nodes in use. Most edges
	// land inside the graph; some repeat the previous pair to exercise the keep-lighter
	// rule, and some are noise over the whole index range (mostly dropped).
	task automatic load_and_solve(int used, int edges);
		logic [NODE_W-1:0]   f;
		logic [NODE_W-1:0]   t;
		logic [NODE_W-1:0]   last_f;
		logic [NODE_W-1:0]   last_t;
		logic [WEIGHT_W-1:0] w;
		int                  pick;
		last_f = '0;
		last_t = '0;
		repeat (edges) begin
			pick = int'($urandom_range(0, 9));
			if (used == 0 || pick == 0) begin
				f = NODE_W'($urandom);
				t = NODE_W'($urandom);
			end else if (pick == 1) begin
				f = last_f;
				t = last_t;
			end else begin
				f = NODE_W'($urandom_range(0, used - 1));
				t = NODE_W'($urandom_range(0, used - 1));
			end
			// Small weights give rich relaxation; full-range ones toggle every bit
			if ($urandom_range(0, 2) == 0)
				w = WEIGHT_W'($urandom_range(0, 65535));
			else
				w = WEIGHT_W'($urandom_range(0, 40));
			push(gdr_pkg::CMD_ADD_EDGE, f, t, w);
			last_f = f;
			last_t = t;
		end
		push(gdr_pkg::CMD_COMPUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
		// Now and then wait out the compute before loading the next graph
		if ($urandom_range(0, 3) == 0)
			settle();
	endtask

	// Receiver: after each taken result draw a stall count, and spend it only while a
	// result is actually on offer, so stalls hit the result rather than the long sweep.
	initial begin
		int hold;
		hold = int'($urandom_range(0, 15));
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			rsp_stall <= (hold > 0);
			if (rsp_valid && hold > 0)
				hold--;
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				hold = calm_rx ? 0 : int'($urandom_range(0, 15));
		end
	end

	// Watchdog: end the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int used;
		int pick;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_valid = 1'b0;
		command = gdr_pkg::CMD_ADD_EDGE;
		from_node = '0;
		to_node = '0;
		weight = '0;
		sent = 0;
		quiet_cycles = 0;
		calm_tx = 1'b0;
		calm_rx = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty graph: the edge is dropped and every result field is zero
		set_node_count(7'd0);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd0, 6'd0, 16'd5);
		push(gdr_pkg::CMD_COMPUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));

		// Single node: a self loop is stored, an edge to node 1 is out of range
		settle();
		set_node_count(7'd1);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd0, 6'd0, 16'd7);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd0, 6'd1, 16'd3);
		push(gdr_pkg::CMD_COMPUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));

		// Two nodes with no positive pair: first no edges, then zero-weight edges
		settle();
		set_node_count(7'd2);
		push(gdr_pkg::CMD_COMPUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
		push(gdr_pkg::CMD_ADD_EDGE, 6'd0, 6'd1, 16'd0);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd1, 6'd0, 16'd0);
		push(gdr_pkg::CMD_COMPUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));

		// Three nodes: repeated pair keeps the lightest, max weight, self loop, cycle
		settle();
		set_node_count(7'd3);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd0, 6'd1, 16'd10);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd0, 6'd1, 16'd4);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd0, 6'd1, 16'd9);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd1, 6'd2, 16'hFFFF);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd2, 6'd2, 16'd1);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd2, 6'd0, 16'd0);
		push(gdr_pkg::CMD_COMPUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));

		// Full node range with top indices and alternating weight patterns; most
		// pairs stay unreachable
		settle();
		set_node_count(COUNT_W'(gdr_pkg::MAX_NODES));
		push(gdr_pkg::CMD_ADD_EDGE, 6'd63, 6'd62, 16'hAAAA);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd62, 6'd63, 16'h5555);
		push(gdr_pkg::CMD_ADD_EDGE, 6'd0, 6'd63, 16'd0);
		push(gdr_pkg::CMD_COMPUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));

		// Random phases: mostly small graphs, since the sweep is cubic in node count
		while (sent < ITEM_GOAL - CHAIN_ITEMS) begin
			pick = int'($urandom_range(0, 19));
			if (pick == 0)
				used = 0;
			else if (pick == 1)
				used = 1;
			else if (pick <= 4)
				used = int'($urandom_range(9, 16));
			else
				used = int'($urandom_range(2, 8));
			settle();
			set_node_count(COUNT_W'(used));
			calm_tx = ($urandom_range(0, 3) == 0);
			calm_rx = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3))
				load_and_solve(used, int'($urandom_range(3, 40)));
		end

		// Oversized node_count acts as the full range; a max-weight chain across all
		// nodes gives the largest diameter any graph can reach, which the fields still carry
		settle();
		set_node_count(7'd127);
		calm_tx = 1'b0;
		calm_rx = 1'b0;
		for (int i = 0; i < gdr_pkg::MAX_NODES - 1; i++)
			push(gdr_pkg::CMD_ADD_EDGE, NODE_W'(i), NODE_W'(i + 1), 16'hFFFF);
		push(gdr_pkg::CMD_COMPUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
src/gdr_pkg.sv
src/gdr_edge_store.sv
src/gdr_dist_store.sv
src/gdr_relax_unit.sv
src/graph_diameter_radius_unit.sv
bench/gdr_checker.sv
bench/tb.sv
